FILE: design/bpc_pkg.sv
// Shared types, constants and helpers for the button press classifier.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int unsigned PIN_W          = 4;
    localparam int unsigned PIN_COUNT_DEF  = 4;
    localparam int unsigned TICK_W         = 10;
    localparam int unsigned TIME_W         = 16;
    localparam int unsigned COUNT_W        = 8;
    localparam int unsigned MSG_W          = 2;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 16;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [PIN_W-1:0]  RST_PIN_ENABLE  = 4'd15;
    localparam logic [TICK_W-1:0] RST_TICK_PERIOD = 10'd10;
    localparam logic [TIME_W-1:0] RST_QUICK_LIMIT = 16'd300;
    localparam logic [TIME_W-1:0] RST_LONG_PRESS  = 16'd1000;
    localparam logic [TIME_W-1:0] RST_SHORT_PRESS = 16'd400;
    localparam logic [TIME_W-1:0] RST_IDLE_LIMIT  = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIN_ENABLE  = 3'd0,
        REG_TICK_PERIOD = 3'd1,
        REG_QUICK_LIMIT = 3'd2,
        REG_LONG_PRESS  = 3'd3,
        REG_SHORT_PRESS = 3'd4,
        REG_IDLE_LIMIT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [MSG_W-1:0] {
        MSG_SHORT  = 2'd0,
        MSG_MEDIUM = 2'd1,
        MSG_LONG   = 2'd2,
        MSG_IDLE   = 2'd3
    } t_msg;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_enable;
        logic [TICK_W-1:0] tick_period_ms;
        logic [TIME_W-1:0] quick_limit_ms;
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] short_press_ms;
        logic [TIME_W-1:0] idle_limit_ms;
    } t_cfg;

    typedef struct packed {
        t_msg               message;
        logic [COUNT_W-1:0] click_count;
        logic [TIME_W-1:0]  held_ms;
        logic [TIME_W-1:0]  gap_ms;
    } t_result;

    // Pins at or above the pin count do not exist.
    function automatic logic [PIN_W-1:0] pin_mask(input int unsigned count);
        logic [PIN_W-1:0] m;
        m = '0;
        for (int unsigned i = 0; i < PIN_W; i++) begin
            m[i] = (i < count);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: design/bpc_cfg.sv
// Configuration register file for the button press classifier.
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg #(
    parameter int unsigned PIN_COUNT = bpc_pkg::PIN_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bpc_pkg::t_cfg                        o_cfg
);
    import bpc_pkg::*;

    localparam logic [PIN_W-1:0] PIN_MASK = pin_mask(PIN_COUNT);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_enable     <= RST_PIN_ENABLE & PIN_MASK;
            r_cfg.tick_period_ms <= RST_TICK_PERIOD;
            r_cfg.quick_limit_ms <= RST_QUICK_LIMIT;
            r_cfg.long_press_ms  <= RST_LONG_PRESS;
            r_cfg.short_press_ms <= RST_SHORT_PRESS;
            r_cfg.idle_limit_ms  <= RST_IDLE_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_PIN_ENABLE:  r_cfg.pin_enable     <= i_cfg_data[PIN_W-1:0] & PIN_MASK;
                REG_TICK_PERIOD: r_cfg.tick_period_ms <= i_cfg_data[TICK_W-1:0];
                REG_QUICK_LIMIT: r_cfg.quick_limit_ms <= i_cfg_data[TIME_W-1:0];
                REG_LONG_PRESS:  r_cfg.long_press_ms  <= i_cfg_data[TIME_W-1:0];
                REG_SHORT_PRESS: r_cfg.short_press_ms <= i_cfg_data[TIME_W-1:0];
                REG_IDLE_LIMIT:  r_cfg.idle_limit_ms  <= i_cfg_data[TIME_W-1:0];
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/bpc_core.sv
// Button timing state and per-tick classification logic.
`timescale 1ns / 1ps
`default_nettype none

module bpc_core #(
    parameter int unsigned PIN_COUNT = bpc_pkg::PIN_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bpc_pkg::t_cfg               i_cfg,
    input  wire logic [bpc_pkg::PIN_W-1:0]   i_levels,
    input  wire logic                        i_advance,
    output logic                             o_has_result,
    output bpc_pkg::t_result                 o_result
);
    import bpc_pkg::*;

    localparam logic [PIN_W-1:0] PIN_MASK = pin_mask(PIN_COUNT);

    logic               r_down,  n_down;
    logic [TIME_W-1:0]  r_since, n_since;
    logic [TIME_W-1:0]  r_held,  n_held;
    logic [TIME_W-1:0]  r_gap,   n_gap;
    logic [COUNT_W-1:0] r_count, n_count;

    logic              pressed;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] time_sat;
    logic              quick;
    t_msg              press_msg;

    always_comb begin
        pressed  = |(~i_levels & i_cfg.pin_enable & PIN_MASK);
        time_sum = {1'b0, r_since} + {{(TIME_W + 1 - TICK_W){1'b0}}, i_cfg.tick_period_ms};
        time_sat = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
        quick    = (time_sat < i_cfg.quick_limit_ms) && (r_gap < i_cfg.quick_limit_ms);

        priority if (time_sat >= i_cfg.long_press_ms) begin
            press_msg = MSG_LONG;
        end else if (time_sat <= i_cfg.short_press_ms) begin
            press_msg = MSG_SHORT;
        end else begin
            press_msg = MSG_MEDIUM;
        end
    end

    always_comb begin
        n_down       = r_down;
        n_since      = time_sat;
        n_held       = r_held;
        n_gap        = r_gap;
        n_count      = r_count;
        o_has_result = 1'b0;
        o_result.message = MSG_IDLE;

        priority if (pressed && !r_down) begin
            // press edge: capture the gap
            n_down  = 1'b1;
            n_gap   = time_sat;
            n_since = '0;
        end else if (!pressed && r_down) begin
            // release edge: capture the hold and report it
            n_down  = 1'b0;
            n_held  = time_sat;
            n_since = '0;
            if (quick) begin
                n_count = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 1'b1;
            end else begin
                n_count = {{(COUNT_W - 1){1'b0}}, 1'b1};
            end
            o_has_result     = 1'b1;
            o_result.message = press_msg;
        end else if (!r_down && (time_sat >= i_cfg.idle_limit_ms) && (r_count != '0)) begin
            n_count          = '0;
            o_has_result     = 1'b1;
            o_result.message = MSG_IDLE;
        end else begin
            // no edge and no idle timeout: only time advances
        end

        o_result.click_count = n_count;
        o_result.held_ms     = n_held;
        o_result.gap_ms      = n_gap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down  <= 1'b0;
            r_since <= '0;
            r_held  <= '0;
            r_gap   <= '0;
            r_count <= '0;
        end else if (i_advance) begin
            r_down  <= n_down;
            r_since <= n_since;
            r_held  <= n_held;
            r_gap   <= n_gap;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: design/button_press_classifier.sv
// Top level of the button press classifier: channel registers and submodules.
`timescale 1ns / 1ps
`default_nettype none

// One pin sample per clock while the input is not stalled. A sample
// is captured in the input register, classified combinationally against the
// timing state, and any message lands in the result register, so a message
// passes the input register and then the result register. The throughput is
// set by the state loop (one saturating add and a few 16-bit compares). The
// input stalls only when a sample would produce a message while the result
// register is full and stalled. Configuration writes are always ready.
module button_press_classifier #(
    parameter int unsigned PIN_COUNT = bpc_pkg::PIN_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [bpc_pkg::PIN_W-1:0]       i_pin_levels,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [bpc_pkg::MSG_W-1:0]            o_message,
    output logic [bpc_pkg::COUNT_W-1:0]          o_click_count,
    output logic [bpc_pkg::TIME_W-1:0]           o_held_ms,
    output logic [bpc_pkg::TIME_W-1:0]           o_gap_ms,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpc_pkg::*;

    t_cfg             cfg;
    t_result          core_result;
    logic             core_has_result;
    logic             in_take;
    logic             out_free;
    logic             advance;

    logic             r_in_valid;
    logic [PIN_W-1:0] r_levels;
    logic             r_out_valid;
    t_result          r_result;

    assign o_cfg_ready = 1'b1;

    bpc_cfg #(
        .PIN_COUNT (PIN_COUNT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bpc_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_levels     (r_levels),
        .i_advance    (advance),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    // A sample with no message moves on even while the result register waits.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!core_has_result || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_levels <= i_pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_has_result) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_message     = r_result.message;
    assign o_click_count = r_result.click_count;
    assign o_held_ms     = r_result.held_ms;
    assign o_gap_ms      = r_result.gap_ms;

    // An idle message always reports a cleared count.
    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_message == MSG_IDLE)) |-> (o_click_count == '0))
        else $error("idle message with nonzero press count");

    // A press message always reports at least one press.
    a_press_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_message != MSG_IDLE)) |-> (o_click_count != '0))
        else $error("press message with zero press count");

    // The input is held back only by a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall && core_has_result))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
